[design/tis_pkg.sv]
// Shared types, constants and helper functions for the triangle isoline block.
// No dependencies.
package tis_pkg;

  localparam int LvlW = 37;

  localparam logic [1:0] PIV_A = 2'd0;
  localparam logic [1:0] PIV_B = 2'd1;
  localparam logic [1:0] PIV_C = 2'd2;

  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_STEP  = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  localparam logic [30:0] RATIO_ONE = 31'h4000_0000;
  localparam logic [63:0] ROUND_HALF = 64'h2000_0000;

  typedef logic [2:0][31:0] trio_t;
  typedef logic [2:0][2:0][31:0] pos_t;

  typedef struct packed {
    logic [1:0]             pivot;
    logic [4:0]             k;
    logic signed [LvlW-1:0] lvl;
    logic                   last;
  } seg_job_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_SCAN,
    FR_FLUSH
  } front_state_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RSETUP,
    BK_RDIV,
    BK_LERP,
    BK_EMIT
  } back_state_e;

  function automatic logic [1:0] first_tgt(input logic [1:0] piv);
    logic [1:0] t;
    case (piv)
      PIV_A: t = PIV_B;
      default: t = PIV_A;
    endcase
    return t;
  endfunction

  function automatic logic [1:0] second_tgt(input logic [1:0] piv);
    logic [1:0] t;
    case (piv)
      PIV_C: t = PIV_B;
      default: t = PIV_C;
    endcase
    return t;
  endfunction

  function automatic logic in_span(input logic signed [LvlW-1:0] l,
                                   input logic signed [31:0] x,
                                   input logic signed [31:0] y);
    logic signed [LvlW-1:0] xe;
    logic signed [LvlW-1:0] ye;
    xe = LvlW'(x);
    ye = LvlW'(y);
    return ((l >= xe) && (l <= ye)) || ((l >= ye) && (l <= xe));
  endfunction

endpackage

[design/tis_front.sv]
// Front end: scans iso levels per pivot and queues one job per shared level.
// Depends on tis_pkg.
module tis_front import tis_pkg::*; #(
  parameter int MaxLevels = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] base_i,
  input  logic [30:0]        step_i,
  input  logic [4:0]         count_i,
  input  trio_t              vals_i,
  input  logic               full_i,
  output logic               push_o,
  output seg_job_t           job_o,
  output logic               busy_o
);

  front_state_e state_q, state_d;
  logic [1:0] piv_q, piv_d;
  logic [4:0] k_q, k_d;
  logic signed [LvlW-1:0] lvl_q, lvl_d;
  seg_job_t pend_q, pend_d;
  logic pend_vld_q, pend_vld_d;

  logic [4:0] cnt;
  logic [30:0] step_eff;
  logic hit, stall, scan_end;

  assign cnt = (count_i > 5'(MaxLevels)) ? 5'(MaxLevels) : count_i;
  assign step_eff = (step_i == '0) ? 31'd1 : step_i;
  assign hit = in_span(lvl_q, vals_i[piv_q], vals_i[first_tgt(piv_q)]) &&
               in_span(lvl_q, vals_i[piv_q], vals_i[second_tgt(piv_q)]);
  assign stall = hit && pend_vld_q && full_i;
  assign scan_end = (k_q == cnt) && (piv_q == PIV_C);

  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: if (start_i) state_d = FR_SCAN;
      FR_SCAN: if (!stall && scan_end) state_d = FR_FLUSH;
      FR_FLUSH: if (!pend_vld_q || !full_i) state_d = FR_IDLE;
      default: state_d = FR_IDLE;
    endcase
  end

  always_comb begin
    piv_d = piv_q;
    k_d = k_q;
    lvl_d = lvl_q;
    pend_d = pend_q;
    pend_vld_d = pend_vld_q;
    push_o = 1'b0;
    job_o = pend_q;
    job_o.last = (state_q == FR_FLUSH);
    case (state_q)
      FR_IDLE: begin
        if (start_i) begin
          piv_d = PIV_A;
          k_d = '0;
          lvl_d = LvlW'(base_i);
          pend_vld_d = 1'b0;
        end
      end
      FR_SCAN: begin
        if (!stall) begin
          if (hit) begin
            push_o = pend_vld_q;
            pend_d = '{pivot: piv_q, k: k_q, lvl: lvl_q, last: 1'b0};
            pend_vld_d = 1'b1;
          end
          if (k_q == cnt) begin
            if (piv_q != PIV_C) begin
              piv_d = piv_q + 2'd1;
              k_d = '0;
              lvl_d = LvlW'(base_i);
            end
          end else begin
            k_d = k_q + 5'd1;
            lvl_d = lvl_q + LvlW'(step_eff);
          end
        end
      end
      FR_FLUSH: begin
        if (pend_vld_q && !full_i) begin
          push_o = 1'b1;
          pend_vld_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      pend_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    piv_q <= piv_d;
    k_q <= k_d;
    lvl_q <= lvl_d;
    pend_q <= pend_d;
  end

  assign busy_o = (state_q != FR_IDLE);

endmodule

[design/tis_fifo.sv]
// Four-entry job queue between the level scanner and the segment engine.
// Depends on tis_pkg.
module tis_fifo import tis_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  seg_job_t job_i,
  input  logic     pop_i,
  output seg_job_t job_o,
  output logic     full_o,
  output logic     empty_o
);

  seg_job_t mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 2'd1;
      if (pop_i) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  assign job_o = mem_q[rd_q];
  assign full_o = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);

endmodule

[design/tis_back.sv]
// Segment engine: bit-serial ratio division and split-multiply interpolation.
// Depends on tis_pkg.
module tis_back import tis_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  seg_job_t    job_i,
  input  trio_t       vals_i,
  input  pos_t        pos_i,
  output logic        pop_o,
  output logic        busy_o,
  output logic        valid_o,
  output logic [31:0] start_x_o,
  output logic [31:0] start_y_o,
  output logic [31:0] start_z_o,
  output logic [31:0] end_x_o,
  output logic [31:0] end_y_o,
  output logic [31:0] end_z_o,
  output logic [4:0]  level_index_o,
  output logic        last_segment_o
);

  back_state_e state_q, state_d;
  seg_job_t job_q, job_d;
  logic edge_q, edge_d;
  logic [30:0] r1_q, r1_d, r2_q, r2_d;
  logic [32:0] rem_q, rem_d, den_q, den_d;
  logic [29:0] quo_q, quo_d;
  logic [4:0] it_q, it_d;
  logic [2:0] coord_q, coord_d;
  logic [1:0] ph_q, ph_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] res_q [6];
  logic [31:0] res_d;
  logic valid_q;
  logic [31:0] out_q [6];
  logic [4:0] lvl_idx_q;
  logic last_q;

  logic signed [31:0] s_val, t_val;
  logic signed [37:0] num;
  logic signed [32:0] den;
  logic [37:0] an;
  logic [32:0] ad;
  logic [33:0] rem2;
  logic ge;
  logic [30:0] r_new;
  logic r_done;
  logic [1:0] axis, tgt;
  logic signed [31:0] p_c, q_c;
  logic signed [32:0] diff;
  logic [32:0] mag;
  logic [30:0] r_sel;
  logic [63:0] rnd;
  logic signed [34:0] sum;

  always_comb begin
    s_val = vals_i[job_q.pivot];
    t_val = edge_q ? vals_i[second_tgt(job_q.pivot)] : vals_i[first_tgt(job_q.pivot)];
    num = 38'(job_q.lvl) - 38'(s_val);
    den = 33'(t_val) - 33'(s_val);
    an = num[37] ? 38'(-num) : 38'(num);
    ad = den[32] ? 33'(-den) : 33'(den);
    rem2 = {rem_q, 1'b0};
    ge = (rem2 >= {1'b0, den_q});
    axis = (coord_q < 3'd3) ? coord_q[1:0] : 2'(coord_q - 3'd3);
    tgt = (coord_q < 3'd3) ? first_tgt(job_q.pivot) : second_tgt(job_q.pivot);
    p_c = pos_i[job_q.pivot][axis];
    q_c = pos_i[tgt][axis];
    r_sel = (coord_q < 3'd3) ? r1_q : r2_q;
    diff = 33'(q_c) - 33'(p_c);
    mag = diff[32] ? 33'(-diff) : 33'(diff);
    rnd = (acc_q + ROUND_HALF) >> 30;
    sum = diff[32] ? (35'(p_c) - $signed({1'b0, rnd[33:0]}))
                   : (35'(p_c) + $signed({1'b0, rnd[33:0]}));
    res_d = sum[31:0];
  end

  always_comb begin
    r_done = 1'b0;
    r_new = '0;
    case (state_q)
      BK_RSETUP: begin
        if (den == '0) begin
          r_done = 1'b1;
        end else if (an >= {5'b0, ad}) begin
          r_done = 1'b1;
          r_new = RATIO_ONE;
        end
      end
      BK_RDIV: begin
        r_done = (it_q == 5'd29);
        r_new = {1'b0, quo_q[28:0], ge};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (!empty_i) state_d = BK_RSETUP;
      BK_RSETUP: begin
        if (r_done) state_d = edge_q ? BK_LERP : BK_RSETUP;
        else state_d = BK_RDIV;
      end
      BK_RDIV: if (r_done) state_d = edge_q ? BK_LERP : BK_RSETUP;
      BK_LERP: if (ph_q == 2'd2 && coord_q == 3'd5) state_d = BK_EMIT;
      BK_EMIT: state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    job_d = job_q;
    edge_d = edge_q;
    r1_d = r1_q;
    r2_d = r2_q;
    rem_d = rem_q;
    den_d = den_q;
    quo_d = quo_q;
    it_d = it_q;
    coord_d = coord_q;
    ph_d = ph_q;
    acc_d = acc_q;
    pop_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          job_d = job_i;
          edge_d = 1'b0;
        end
      end
      BK_RSETUP: begin
        rem_d = an[32:0];
        den_d = ad;
        quo_d = '0;
        it_d = '0;
      end
      BK_RDIV: begin
        rem_d = ge ? 33'(rem2 - {1'b0, den_q}) : rem2[32:0];
        quo_d = {quo_q[28:0], ge};
        it_d = it_q + 5'd1;
      end
      BK_LERP: begin
        case (ph_q)
          2'd0: begin
            acc_d = 64'(47'(mag[15:0]) * 47'(r_sel));
            ph_d = 2'd1;
          end
          2'd1: begin
            acc_d = acc_q + (64'(48'(mag[32:16]) * 48'(r_sel)) << 16);
            ph_d = 2'd2;
          end
          default: begin
            ph_d = 2'd0;
            coord_d = coord_q + 3'd1;
          end
        endcase
      end
      default: ;
    endcase
    if (r_done) begin
      if (edge_q) r2_d = r_new;
      else r1_d = r_new;
      edge_d = 1'b1;
      coord_d = '0;
      ph_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == BK_EMIT);
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    edge_q <= edge_d;
    r1_q <= r1_d;
    r2_q <= r2_d;
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
    it_q <= it_d;
    coord_q <= coord_d;
    ph_q <= ph_d;
    acc_q <= acc_d;
    if (state_q == BK_LERP && ph_q == 2'd2) res_q[coord_q] <= res_d;
    if (state_q == BK_EMIT) begin
      out_q <= res_q;
      lvl_idx_q <= job_q.k;
      last_q <= job_q.last;
    end
  end

  assign busy_o = (state_q != BK_IDLE);
  assign valid_o = valid_q;
  assign start_x_o = out_q[0];
  assign start_y_o = out_q[1];
  assign start_z_o = out_q[2];
  assign end_x_o = out_q[3];
  assign end_y_o = out_q[4];
  assign end_z_o = out_q[5];
  assign level_index_o = lvl_idx_q;
  assign last_segment_o = last_q;

endmodule

[design/triangle_isoline_segments.sv]
// Isoline segments of one triangle. The level scanner visits levels 0 to c for each pivot, with
// c = min(count, MAX_LEVELS), then flushes, and stalls when a job must enter the full 4-entry queue.
// Each segment is then dequeued, gets its two ratios from the one-bit-per-cycle divider, has its
// six coordinates interpolated and is emitted; its strobe comes in the cycle after.
// busy stays high from the start transfer until the cycle of the last strobe, in which the next
// triangle can transfer; no results, no strobe. Reset loads base 0, step 1.0, count 8.
module triangle_isoline_segments import tis_pkg::*; #(
  parameter int MAX_LEVELS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] value_a_i,
  input  logic [31:0] value_b_i,
  input  logic [31:0] value_c_i,
  input  logic [31:0] ax_i,
  input  logic [31:0] ay_i,
  input  logic [31:0] az_i,
  input  logic [31:0] bx_i,
  input  logic [31:0] by_i,
  input  logic [31:0] bz_i,
  input  logic [31:0] cx_i,
  input  logic [31:0] cy_i,
  input  logic [31:0] cz_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output logic        valid_o,
  output logic [31:0] start_x_o,
  output logic [31:0] start_y_o,
  output logic [31:0] start_z_o,
  output logic [31:0] end_x_o,
  output logic [31:0] end_y_o,
  output logic [31:0] end_z_o,
  output logic [4:0]  level_index_o,
  output logic        last_segment_o
);

  logic signed [31:0] base_q;
  logic [30:0] step_q;
  logic [4:0] count_q;
  trio_t vals_q;
  pos_t pos_q;
  logic accept;
  logic fr_busy, bk_busy, push, pop, full, empty;
  seg_job_t job_in, job_out;

  assign accept = start && !busy;
  assign busy = fr_busy || !empty || bk_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      step_q <= 31'd65536;
      count_q <= 5'd8;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE: base_q <= cfg_data_i;
        CFG_STEP: step_q <= cfg_data_i[30:0];
        CFG_COUNT: count_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      vals_q <= {value_c_i, value_b_i, value_a_i};
      pos_q <= {{cz_i, cy_i, cx_i}, {bz_i, by_i, bx_i}, {az_i, ay_i, ax_i}};
    end
  end

  tis_front #(.MaxLevels(MAX_LEVELS)) u_front (
    .clk_i, .rst_ni,
    .start_i(accept),
    .base_i(base_q),
    .step_i(step_q),
    .count_i(count_q),
    .vals_i(vals_q),
    .full_i(full),
    .push_o(push),
    .job_o(job_in),
    .busy_o(fr_busy)
  );

  tis_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(push),
    .job_i(job_in),
    .pop_i(pop),
    .job_o(job_out),
    .full_o(full),
    .empty_o(empty)
  );

  tis_back u_back (
    .clk_i, .rst_ni,
    .empty_i(empty),
    .job_i(job_out),
    .vals_i(vals_q),
    .pos_i(pos_q),
    .pop_o(pop),
    .busy_o(bk_busy),
    .valid_o,
    .start_x_o, .start_y_o, .start_z_o,
    .end_x_o, .end_y_o, .end_z_o,
    .level_index_o,
    .last_segment_o
  );

endmodule
